// ===== rtl/ssf_pkg.sv =====
// Shared types, codes and sizes of the stereo sample FIFO.
package ssf_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int FUNC_W        = 2;
    localparam int STAT_W        = 3;
    localparam int CNT_W         = 7;
    localparam int LEVEL_W       = 11;
    localparam int CAP_W         = 11;
    localparam int MAX_POP       = 64;
    localparam int DEPTH_DEFAULT = 1024;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Command queue between front and back, and result queue at the output
    localparam int CMDQ_DEPTH = 2;
    localparam int CQ_AW      = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CQ_CW      = $clog2(CMDQ_DEPTH + 1);
    localparam int RQ_DEPTH   = 4;
    localparam int RQ_AW      = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
    localparam int RQ_CW      = $clog2(RQ_DEPTH + 1);

    // Operation codes on the func field
    localparam logic [FUNC_W-1:0] FUNC_PUSH     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SHUTDOWN = 2'd3;

    typedef enum logic [2:0] {
        KIND_PUSH     = 3'd0,
        KIND_POP      = 3'd1,
        KIND_FLUSH    = 3'd2,
        KIND_SHUTDOWN = 3'd3,
        KIND_EMPTYREQ = 3'd4
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_PUSHED   = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_DROPPED  = 3'd2,
        STAT_POPPED   = 3'd3,
        STAT_ZERO     = 3'd4,
        STAT_FLUSHED  = 3'd5,
        STAT_SHUTDOWN = 3'd6,
        STAT_EMPTYREQ = 3'd7
    } stat_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [CNT_W-1:0]           count;
    } cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        stat_t                      status;
        logic                       last;
        logic [CNT_W-1:0]           got;
        logic [LEVEL_W-1:0]         fill;
    } res_t;

    // Effective capacity: zero acts as one, above the store depth acts as the depth
    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap,
                                                 input int unsigned depth);
        logic [CAP_W-1:0] c;
        c = cap;
        if (cap == '0)
        begin
            c = CAP_W'(1);
        end
        else if (32'(cap) > depth)
        begin
            c = CAP_W'(depth);
        end
        return c;
    endfunction

endpackage

// ===== rtl/stereo_sample_fifo_top.sv =====
// Top level of the stereo sample FIFO: front end, back end and result queue.
//
// Channel   Direction  Handshake              Payload
// command   in         push / full            func, left_in, right_in, frames_requested
// result    out        empty / pop            left_out, right_out, status, last,
//                                             got_count, fill_level
// config    in         cfg_valid / cfg_ready  capacity
//
// Push, flush, shutdown and an empty pop request each issue a single result from the back end;
// a pop of N frames (N up to 64) issues N results, one frame a cycle while the back end is not
// stalled, through the single store read port. A result passes from the command slot through
// the back end's result register into the result queue, whose head can then be popped.
// Reset clears pointers, fill count and the shutdown mark; the frame store is not cleared.
// full rises when two decoded commands wait; the back end stalls while the result
// queue and the result in flight fill its four slots.
module stereo_sample_fifo_top #(
    parameter int DEPTH = ssf_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [ssf_pkg::FUNC_W-1:0]          func,
    input  logic signed [ssf_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [ssf_pkg::SAMPLE_W-1:0] right_in,
    input  logic [ssf_pkg::CNT_W-1:0]           frames_requested,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [ssf_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [ssf_pkg::SAMPLE_W-1:0] right_out,
    output logic [ssf_pkg::STAT_W-1:0]          status,
    output logic                                last,
    output logic [ssf_pkg::CNT_W-1:0]           got_count,
    output logic [ssf_pkg::LEVEL_W-1:0]         fill_level,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssf_pkg::CAP_W-1:0]           capacity
);

    logic                       cmd_valid;
    ssf_pkg::cmd_t              cmd;
    logic                       cmd_take;
    logic                       res_valid;
    ssf_pkg::res_t              res;
    logic [ssf_pkg::RQ_CW-1:0]  rq_count;
    ssf_pkg::res_t              head;

    assign cfg_ready = 1'b1;

    ssf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .func             (func),
        .left_in          (left_in),
        .right_in         (right_in),
        .frames_requested (frames_requested),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd),
        .cmd_take         (cmd_take)
    );

    ssf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_cap   (capacity),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .rq_count  (rq_count),
        .res_valid (res_valid),
        .res       (res)
    );

    ssf_result_queue u_rq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_res   (res),
        .count    (rq_count),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    // Drive the result ports from the queue head
    assign left_out   = head.left;
    assign right_out  = head.right;
    assign status     = head.status;
    assign last       = head.last;
    assign got_count  = head.got;
    assign fill_level = head.fill;

    // The back end never writes into a full result queue
    a_rq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (rq_count < ssf_pkg::RQ_CW'(ssf_pkg::RQ_DEPTH)))
        else $error("result queue overflow");

    // Only pop results can be other than the last of their item
    a_only_pop_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |-> (status == ssf_pkg::STAT_POPPED ||
                               status == ssf_pkg::STAT_ZERO))
        else $error("non-pop result without last");

    // An empty pop request is a single result with no frames taken
    a_emptyreq_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ssf_pkg::STAT_EMPTYREQ) |-> (last && got_count == '0))
        else $error("empty pop request result malformed");

    // A held result stays put while it waits to be taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(fill_level)))
        else $error("waiting result changed");

endmodule

// ===== rtl/ssf_front.sv =====
// Front end: accepts input items, classifies them and queues decoded commands.
module ssf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [ssf_pkg::FUNC_W-1:0]          func,
    input  logic signed [ssf_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [ssf_pkg::SAMPLE_W-1:0] right_in,
    input  logic [ssf_pkg::CNT_W-1:0]           frames_requested,
    output logic                                cmd_valid,
    output ssf_pkg::cmd_t                       cmd,
    input  logic                                cmd_take
);

    ssf_pkg::cmd_t                   slot_reg [ssf_pkg::CMDQ_DEPTH];
    logic [ssf_pkg::CQ_AW-1:0]       head_reg, head_next;
    logic [ssf_pkg::CQ_AW-1:0]       tail_reg, tail_next;
    logic [ssf_pkg::CQ_CW-1:0]       count_reg, count_next;
    ssf_pkg::cmd_t                   decoded;
    logic [ssf_pkg::CNT_W-1:0]       count_sat;
    logic                            accept;
    logic                            take;

    // Classify the item and saturate the pop length
    always_comb
    begin
        count_sat = (frames_requested > ssf_pkg::CNT_W'(ssf_pkg::MAX_POP))
                    ? ssf_pkg::CNT_W'(ssf_pkg::MAX_POP) : frames_requested;
        decoded.left  = left_in;
        decoded.right = right_in;
        decoded.count = count_sat;
        unique case (func)
            ssf_pkg::FUNC_PUSH:     decoded.kind = ssf_pkg::KIND_PUSH;
            ssf_pkg::FUNC_POP:      decoded.kind = (frames_requested == '0)
                                                   ? ssf_pkg::KIND_EMPTYREQ
                                                   : ssf_pkg::KIND_POP;
            ssf_pkg::FUNC_FLUSH:    decoded.kind = ssf_pkg::KIND_FLUSH;
            ssf_pkg::FUNC_SHUTDOWN: decoded.kind = ssf_pkg::KIND_SHUTDOWN;
            default:                decoded.kind = ssf_pkg::KIND_SHUTDOWN;
        endcase
    end

    assign full      = (count_reg == ssf_pkg::CQ_CW'(ssf_pkg::CMDQ_DEPTH));
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign take      = cmd_take && cmd_valid;
    assign cmd       = slot_reg[head_reg];

    // Advance queue pointers and count
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (accept)
        begin
            tail_next = (tail_reg == ssf_pkg::CQ_AW'(ssf_pkg::CMDQ_DEPTH - 1))
                        ? '0 : tail_reg + 1'b1;
        end
        if (take)
        begin
            head_next = (head_reg == ssf_pkg::CQ_AW'(ssf_pkg::CMDQ_DEPTH - 1))
                        ? '0 : head_reg + 1'b1;
        end
        if (accept && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !accept)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store the decoded command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[tail_reg] <= decoded;
        end
    end

endmodule

// ===== rtl/ssf_back.sv =====
// Back end: executes commands on the frame store and issues one result a cycle while it is not stalled.
module ssf_back #(
    parameter int DEPTH = ssf_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ssf_pkg::CAP_W-1:0]       cfg_cap,
    input  logic                            cmd_valid,
    input  ssf_pkg::cmd_t                   cmd,
    output logic                            cmd_take,
    input  logic [ssf_pkg::RQ_CW-1:0]       rq_count,
    output logic                            res_valid,
    output ssf_pkg::res_t                   res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_POP  = 2'b10
    } bst_t;

    logic [2*ssf_pkg::SAMPLE_W-1:0] store [DEPTH];
    logic [2*ssf_pkg::SAMPLE_W-1:0] rdata_reg;

    bst_t                          state_reg, state_next;
    logic [PW-1:0]                 wp_reg, wp_next;
    logic [PW-1:0]                 rp_reg, rp_next;
    logic [ssf_pkg::LEVEL_W-1:0]   held_reg, held_next;
    logic                          stopped_reg, stopped_next;
    logic [ssf_pkg::CAP_W-1:0]     cap_reg, cap_next;
    logic [ssf_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [ssf_pkg::CNT_W-1:0]     got_reg, got_next;
    logic                          s1_valid_reg, s1_valid_next;
    ssf_pkg::res_t                 s1_res_reg, s1_res_next;
    logic                          s1_popped_reg, s1_popped_next;

    logic                          space;
    logic                          in_pop;
    logic                          step;
    ssf_pkg::kind_t                cur_kind;
    logic [ssf_pkg::CNT_W-1:0]     rem;
    logic [ssf_pkg::CNT_W-1:0]     got_base;
    logic [ssf_pkg::CNT_W-1:0]     got_step;
    logic                          is_last;
    ssf_pkg::stat_t                stat;
    logic                          wr_en;
    logic                          rd_en;

    function automatic logic [PW-1:0] ptr_adv(input logic [PW-1:0] p,
                                              input logic [ssf_pkg::CAP_W-1:0] c);
        logic [31:0] n;
        n = 32'(p) + 32'd1;
        return (n >= 32'(c)) ? '0 : PW'(n);
    endfunction

    // Issue only when the result queue has room for this result and the one in flight
    assign space = ({1'b0, rq_count} + (ssf_pkg::RQ_CW + 1)'(s1_valid_reg))
                   < (ssf_pkg::RQ_CW + 1)'(ssf_pkg::RQ_DEPTH);
    assign in_pop   = (state_reg == B_POP);
    assign cur_kind = in_pop ? ssf_pkg::KIND_POP : cmd.kind;
    assign step     = space && (in_pop || cmd_valid) && !cfg_we;
    assign cmd_take = step && !in_pop;
    assign rem      = in_pop ? rem_reg : cmd.count;
    assign got_base = in_pop ? got_reg : '0;

    // Work out one step of the current command
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        held_next      = held_reg;
        stopped_next   = stopped_reg;
        cap_next       = cap_reg;
        rem_next       = rem_reg;
        got_next       = got_reg;
        got_step       = got_base;
        is_last        = 1'b1;
        stat           = ssf_pkg::STAT_EMPTYREQ;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        s1_popped_next = 1'b0;
        if (cfg_we)
        begin
            cap_next  = ssf_pkg::eff_cap(cfg_cap, DEPTH);
            wp_next   = '0;
            rp_next   = '0;
            held_next = '0;
            state_next = B_IDLE;
        end
        else if (step)
        begin
            unique case (cur_kind)
                ssf_pkg::KIND_PUSH:
                begin
                    if (stopped_reg)
                    begin
                        stat = ssf_pkg::STAT_DROPPED;
                    end
                    else if (held_reg >= cap_reg)
                    begin
                        stat = ssf_pkg::STAT_FULL;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wp_next   = ptr_adv(wp_reg, cap_reg);
                        held_next = held_reg + 1'b1;
                        stat      = ssf_pkg::STAT_PUSHED;
                    end
                end
                ssf_pkg::KIND_POP:
                begin
                    if (held_reg != '0)
                    begin
                        rd_en          = 1'b1;
                        rp_next        = ptr_adv(rp_reg, cap_reg);
                        held_next      = held_reg - 1'b1;
                        got_step       = got_base + 1'b1;
                        s1_popped_next = 1'b1;
                        stat           = ssf_pkg::STAT_POPPED;
                    end
                    else
                    begin
                        stat = ssf_pkg::STAT_ZERO;
                    end
                    is_last    = (rem == ssf_pkg::CNT_W'(1));
                    rem_next   = rem - 1'b1;
                    got_next   = got_step;
                    state_next = is_last ? B_IDLE : B_POP;
                end
                ssf_pkg::KIND_FLUSH:
                begin
                    wp_next   = '0;
                    rp_next   = '0;
                    held_next = '0;
                    stat      = ssf_pkg::STAT_FLUSHED;
                end
                ssf_pkg::KIND_SHUTDOWN:
                begin
                    stopped_next = 1'b1;
                    stat         = ssf_pkg::STAT_SHUTDOWN;
                end
                ssf_pkg::KIND_EMPTYREQ:
                begin
                    stat = ssf_pkg::STAT_EMPTYREQ;
                end
                default:
                begin
                    stat = ssf_pkg::STAT_EMPTYREQ;
                end
            endcase
        end
        s1_valid_next      = step;
        s1_res_next.left   = '0;
        s1_res_next.right  = '0;
        s1_res_next.status = stat;
        s1_res_next.last   = is_last;
        s1_res_next.got    = (is_last && cur_kind == ssf_pkg::KIND_POP) ? got_step : '0;
        s1_res_next.fill   = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            wp_reg       <= '0;
            rp_reg       <= '0;
            held_reg     <= '0;
            stopped_reg  <= 1'b0;
            cap_reg      <= ssf_pkg::eff_cap(ssf_pkg::CAP_RESET, DEPTH);
            rem_reg      <= '0;
            got_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            held_reg     <= held_next;
            stopped_reg  <= stopped_next;
            cap_reg      <= cap_next;
            rem_reg      <= rem_next;
            got_reg      <= got_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Hold the result of the issued step
    always_ff @(posedge clk)
    begin
        s1_res_reg    <= s1_res_next;
        s1_popped_reg <= s1_popped_next;
    end

    // Frame store: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wp_reg] <= {cmd.right, cmd.left};
        end
        if (rd_en)
        begin
            rdata_reg <= store[rp_reg];
        end
    end

    // Merge the read frame into the popped result
    always_comb
    begin
        res = s1_res_reg;
        if (s1_popped_reg)
        begin
            res.left  = rdata_reg[ssf_pkg::SAMPLE_W-1:0];
            res.right = rdata_reg[2*ssf_pkg::SAMPLE_W-1:ssf_pkg::SAMPLE_W];
        end
    end
    assign res_valid = s1_valid_reg;

endmodule

// ===== rtl/ssf_result_queue.sv =====
// Result queue: holds issued results until the consumer pops them.
module ssf_result_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_valid,
    input  ssf_pkg::res_t              wr_res,
    output logic [ssf_pkg::RQ_CW-1:0]  count,
    input  logic                       pop,
    output logic                       empty,
    output ssf_pkg::res_t              head
);

    ssf_pkg::res_t              slot_reg [ssf_pkg::RQ_DEPTH];
    logic [ssf_pkg::RQ_AW-1:0]  head_reg, head_next;
    logic [ssf_pkg::RQ_AW-1:0]  tail_reg, tail_next;
    logic [ssf_pkg::RQ_CW-1:0]  count_reg, count_next;
    logic                       wr;
    logic                       rd;

    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign head  = slot_reg[head_reg];
    assign rd    = pop && !empty;
    assign wr    = wr_valid && (count_reg != ssf_pkg::RQ_CW'(ssf_pkg::RQ_DEPTH));

    // Advance pointers and count
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (wr)
        begin
            tail_next = (tail_reg == ssf_pkg::RQ_AW'(ssf_pkg::RQ_DEPTH - 1))
                        ? '0 : tail_reg + 1'b1;
        end
        if (rd)
        begin
            head_next = (head_reg == ssf_pkg::RQ_AW'(ssf_pkg::RQ_DEPTH - 1))
                        ? '0 : head_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store the incoming result
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[tail_reg] <= wr_res;
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the stereo sample FIFO: directed table, random phases, shadow model.
module testbench;

    typedef enum logic {
        ROW_CMD = 1'b0,
        ROW_CAP = 1'b1
    } row_kind_t;

    // One line of the directed table: a command or a capacity write, and an optional
    // single reply typed in by hand
    typedef struct packed {
        row_kind_t                           kind;
        logic [ssf_pkg::CAP_W-1:0]           cap;
        logic [ssf_pkg::FUNC_W-1:0]          fn;
        logic signed [ssf_pkg::SAMPLE_W-1:0] l;
        logic signed [ssf_pkg::SAMPLE_W-1:0] r;
        logic [ssf_pkg::CNT_W-1:0]           req;
        logic                                typed;
        ssf_pkg::stat_t                      st;
        logic signed [ssf_pkg::SAMPLE_W-1:0] el;
        logic signed [ssf_pkg::SAMPLE_W-1:0] er;
        logic [ssf_pkg::CNT_W-1:0]           eg;
        logic [ssf_pkg::LEVEL_W-1:0]         ef;
    } step_row_t;

    localparam int HEAD_ROWS = 21;
    localparam int TAIL_ROWS = 10;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 48;
    localparam int AFTER_STOP_ITEMS = 20;
    localparam int STORE_SLOTS = ssf_pkg::DEPTH_DEFAULT;

    // Opening commands, run at the reset capacity and then at small and oversized ones
    localparam step_row_t HEAD [HEAD_ROWS] = '{
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_POP, 16'sh0000, 16'sh0000, 7'd0,
          1'b1, ssf_pkg::STAT_EMPTYREQ, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_POP, 16'sh0000, 16'sh0000, 7'd1,
          1'b1, ssf_pkg::STAT_ZERO, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh7FFF, 16'sh8000, 7'd0,
          1'b1, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd1},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh8000, 16'sh7FFF, 7'd0,
          1'b1, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd2},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'shFFFF, 16'sh0000, 7'd0,
          1'b1, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd3},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_POP, 16'sh0000, 16'sh0000, 7'd1,
          1'b1, ssf_pkg::STAT_POPPED, 16'sh7FFF, 16'sh8000, 7'd1, 11'd2},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_POP, 16'sh0000, 16'sh0000, 7'd5,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh5555, 16'shAAAA, 7'd0,
          1'b1, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd1},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'shAAAA, 16'sh5555, 7'd0,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_FLUSH, 16'sh0000, 16'sh0000, 7'd0,
          1'b1, ssf_pkg::STAT_FLUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_POP, 16'sh0000, 16'sh0000, 7'd127,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CAP, 11'd1, ssf_pkg::FUNC_PUSH, 16'sh0000, 16'sh0000, 7'd0,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh1234, 16'sh4321, 7'd0,
          1'b1, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd1},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh0000, 16'sh0000, 7'd0,
          1'b1, ssf_pkg::STAT_FULL, 16'sh0000, 16'sh0000, 7'd0, 11'd1},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_POP, 16'sh0000, 16'sh0000, 7'd3,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CAP, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh0000, 16'sh0000, 7'd0,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh0FF0, 16'shF00F, 7'd0,
          1'b1, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd1},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh0001, 16'sh0001, 7'd0,
          1'b1, ssf_pkg::STAT_FULL, 16'sh0000, 16'sh0000, 7'd0, 11'd1},
        '{ROW_CAP, 11'd2047, ssf_pkg::FUNC_PUSH, 16'sh0000, 16'sh0000, 7'd0,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh2222, 16'shDDDD, 7'd0,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_POP, 16'sh0000, 16'sh0000, 7'd64,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0}
    };

    // Closing commands: shutdown, drops that win over full, and a capacity write that keeps
    // the shutdown mark
    localparam step_row_t TAIL [TAIL_ROWS] = '{
        '{ROW_CAP, 11'd1, ssf_pkg::FUNC_PUSH, 16'sh0000, 16'sh0000, 7'd0,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh0101, 16'shFEFE, 7'd0,
          1'b1, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd1},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_SHUTDOWN, 16'sh0000, 16'sh0000, 7'd0,
          1'b1, ssf_pkg::STAT_SHUTDOWN, 16'sh0000, 16'sh0000, 7'd0, 11'd1},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh7777, 16'sh8888, 7'd0,
          1'b1, ssf_pkg::STAT_DROPPED, 16'sh0000, 16'sh0000, 7'd0, 11'd1},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_POP, 16'sh0000, 16'sh0000, 7'd2,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh3333, 16'shCCCC, 7'd0,
          1'b1, ssf_pkg::STAT_DROPPED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_FLUSH, 16'sh0000, 16'sh0000, 7'd0,
          1'b1, ssf_pkg::STAT_FLUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CAP, 11'd3, ssf_pkg::FUNC_PUSH, 16'sh0000, 16'sh0000, 7'd0,
          1'b0, ssf_pkg::STAT_PUSHED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_PUSH, 16'sh4444, 16'shBBBB, 7'd0,
          1'b1, ssf_pkg::STAT_DROPPED, 16'sh0000, 16'sh0000, 7'd0, 11'd0},
        '{ROW_CMD, 11'd0, ssf_pkg::FUNC_POP, 16'sh0000, 16'sh0000, 7'd0,
          1'b1, ssf_pkg::STAT_EMPTYREQ, 16'sh0000, 16'sh0000, 7'd0, 11'd0}
    };

    // Capacity and idling of each random phase
    localparam logic [ssf_pkg::CAP_W-1:0] PHASE_CAP [PHASES] = '{11'd4, 11'd0, 11'd2047,
                                                                  11'd1, 11'd13, 11'd1024};
    localparam int PHASE_SEND_IDLE [PHASES] = '{0, 54, 0, 18, 54, 0};
    localparam int PHASE_RECV_STALL [PHASES] = '{0, 0, 54, 18, 54, 18};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [ssf_pkg::FUNC_W-1:0] func = ssf_pkg::FUNC_PUSH;
    logic signed [ssf_pkg::SAMPLE_W-1:0] left_in = '0;
    logic signed [ssf_pkg::SAMPLE_W-1:0] right_in = '0;
    logic [ssf_pkg::CNT_W-1:0] frames_requested = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [ssf_pkg::SAMPLE_W-1:0] left_out;
    logic signed [ssf_pkg::SAMPLE_W-1:0] right_out;
    logic [ssf_pkg::STAT_W-1:0] status;
    logic last;
    logic [ssf_pkg::CNT_W-1:0] got_count;
    logic [ssf_pkg::LEVEL_W-1:0] fill_level;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ssf_pkg::CAP_W-1:0] capacity = ssf_pkg::CAP_RESET;

    // Shadow copy of the FIFO and its register
    logic [2*ssf_pkg::SAMPLE_W-1:0] shadow_store [STORE_SLOTS];
    int unsigned shadow_wr = 0;
    int unsigned shadow_rd = 0;
    int unsigned shadow_held = 0;
    logic shadow_stopped = 1'b0;
    logic [ssf_pkg::CAP_W-1:0] shadow_cap = ssf_pkg::CAP_RESET;

    ssf_pkg::res_t replies_due [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int commands_sent = 0;
    int replies_seen = 0;
    int cap_writes = 0;
    int status_tally [8] = '{default: 0};

    stereo_sample_fifo_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .func             (func),
        .left_in          (left_in),
        .right_in         (right_in),
        .frames_requested (frames_requested),
        .empty            (empty),
        .pop              (pop),
        .left_out         (left_out),
        .right_out        (right_out),
        .status           (status),
        .last             (last),
        .got_count        (got_count),
        .fill_level       (fill_level),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .capacity         (capacity)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Slots in use: zero counts as one, anything above the store counts as the store
    function automatic int unsigned slots_in_use();
        int unsigned c;
        c = 32'(shadow_cap);
        if (c == 0)
        begin
            c = 1;
        end
        if (c > STORE_SLOTS)
        begin
            c = STORE_SLOTS;
        end
        return c;
    endfunction

    function automatic int unsigned step_ring(input int unsigned p);
        return (p + 1 >= slots_in_use()) ? 0 : p + 1;
    endfunction

    // Apply one command to the shadow FIFO and queue the replies it owes
    task automatic run_command(input logic [ssf_pkg::FUNC_W-1:0] fn,
                               input logic signed [ssf_pkg::SAMPLE_W-1:0] l,
                               input logic signed [ssf_pkg::SAMPLE_W-1:0] r,
                               input logic [ssf_pkg::CNT_W-1:0] req);
        ssf_pkg::res_t rep;
        int unsigned n;
        int unsigned got;
        logic [2*ssf_pkg::SAMPLE_W-1:0] word;
        rep = '0;
        rep.status = ssf_pkg::STAT_PUSHED;
        rep.last = 1'b1;
        got = 0;
        if (fn == ssf_pkg::FUNC_PUSH)
        begin
            if (shadow_stopped)
            begin
                rep.status = ssf_pkg::STAT_DROPPED;
            end
            else if (shadow_held >= slots_in_use())
            begin
                rep.status = ssf_pkg::STAT_FULL;
            end
            else
            begin
                shadow_store[shadow_wr] = {r, l};
                shadow_wr = step_ring(shadow_wr);
                shadow_held++;
            end
            rep.fill = ssf_pkg::LEVEL_W'(shadow_held);
            replies_due.push_back(rep);
        end
        else if (fn == ssf_pkg::FUNC_POP)
        begin
            if (req == 0)
            begin
                rep.status = ssf_pkg::STAT_EMPTYREQ;
                rep.fill = ssf_pkg::LEVEL_W'(shadow_held);
                replies_due.push_back(rep);
            end
            else
            begin
                n = (32'(req) > 32'(ssf_pkg::MAX_POP)) ? 32'(ssf_pkg::MAX_POP) : 32'(req);
                for (int unsigned i = 0; i < n; i++)
                begin
                    rep = '0;
                    rep.status = ssf_pkg::STAT_ZERO;
                    if (shadow_held > 0)
                    begin
                        word = shadow_store[shadow_rd];
                        rep.left = word[ssf_pkg::SAMPLE_W-1:0];
                        rep.right = word[2*ssf_pkg::SAMPLE_W-1:ssf_pkg::SAMPLE_W];
                        rep.status = ssf_pkg::STAT_POPPED;
                        shadow_rd = step_ring(shadow_rd);
                        shadow_held--;
                        got++;
                    end
                    rep.last = (i + 1 == n);
                    rep.got = rep.last ? ssf_pkg::CNT_W'(got) : '0;
                    rep.fill = ssf_pkg::LEVEL_W'(shadow_held);
                    replies_due.push_back(rep);
                end
            end
        end
        else if (fn == ssf_pkg::FUNC_FLUSH)
        begin
            shadow_wr = 0;
            shadow_rd = 0;
            shadow_held = 0;
            rep.status = ssf_pkg::STAT_FLUSHED;
            rep.fill = '0;
            replies_due.push_back(rep);
        end
        else
        begin
            shadow_stopped = 1'b1;
            rep.status = ssf_pkg::STAT_SHUTDOWN;
            rep.fill = ssf_pkg::LEVEL_W'(shadow_held);
            replies_due.push_back(rep);
        end
    endtask

    // Offer one item, hold it until taken, then queue its replies
    task automatic send_command(input logic [ssf_pkg::FUNC_W-1:0] fn,
                                input logic signed [ssf_pkg::SAMPLE_W-1:0] l,
                                input logic signed [ssf_pkg::SAMPLE_W-1:0] r,
                                input logic [ssf_pkg::CNT_W-1:0] req,
                                input logic typed,
                                input ssf_pkg::res_t typed_reply);
        int gap;
        gap = 0;
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            gap = $urandom_range(4, 1);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        func <= fn;
        left_in <= l;
        right_in <= r;
        frames_requested <= req;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        run_command(fn, l, r, req);
        if (typed)
        begin
            void'(replies_due.pop_back());
            replies_due.push_back(typed_reply);
        end
        commands_sent++;
    endtask

    // Drop push and wait until every owed reply has come back
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (replies_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write the capacity register with the FIFO idle
    task automatic set_capacity(input logic [ssf_pkg::CAP_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        capacity <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        shadow_cap = value;
        shadow_wr = 0;
        shadow_rd = 0;
        shadow_held = 0;
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic play_row(input step_row_t row);
        ssf_pkg::res_t rep;
        if (row.kind == ROW_CAP)
        begin
            set_capacity(row.cap);
        end
        else
        begin
            rep.left = row.el;
            rep.right = row.er;
            rep.status = row.st;
            rep.last = 1'b1;
            rep.got = row.eg;
            rep.fill = row.ef;
            send_command(row.fn, row.l, row.r, row.req, row.typed, rep);
        end
    endtask

    // Random command: mostly pushes, short pops, some long or oversized, few flushes, shutdowns
    task automatic random_command(input bit allow_stop);
        int pick;
        logic [ssf_pkg::FUNC_W-1:0] fn;
        logic signed [ssf_pkg::SAMPLE_W-1:0] l;
        logic signed [ssf_pkg::SAMPLE_W-1:0] r;
        logic [ssf_pkg::CNT_W-1:0] req;
        int unsigned want;
        pick = $urandom_range(99, 0);
        if (allow_stop && pick < 5)
        begin
            fn = ssf_pkg::FUNC_SHUTDOWN;
        end
        else if (pick < 62)
        begin
            fn = ssf_pkg::FUNC_PUSH;
        end
        else if (pick < 92)
        begin
            fn = ssf_pkg::FUNC_POP;
        end
        else
        begin
            fn = ssf_pkg::FUNC_FLUSH;
        end
        l = ssf_pkg::SAMPLE_W'($urandom);
        r = ssf_pkg::SAMPLE_W'($urandom);
        if ($urandom_range(7, 0) == 0)
        begin
            l = $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
            r = $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
        end
        pick = $urandom_range(19, 0);
        if (pick < 2)
        begin
            want = 0;
        end
        else if (pick < 4)
        begin
            want = $urandom_range(127, ssf_pkg::MAX_POP + 1);
        end
        else if (pick < 9)
        begin
            want = shadow_held + $urandom_range(3, 0);
            if (want > 127)
            begin
                want = 127;
            end
        end
        else
        begin
            want = $urandom_range(4, 1);
        end
        req = ssf_pkg::CNT_W'(want);
        send_command(fn, l, r, req, 1'b0, '0);
    endtask

    task automatic note_mismatch(input ssf_pkg::res_t exp, input bit orphan);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (orphan)
            begin
                $display("result %0d with nothing owed:", replies_seen);
                $display("            saw      L=%0d R=%0d st=%0d last=%0d got=%0d fill=%0d",
                         left_out, right_out, status, last, got_count, fill_level);
            end
            else
            begin
                $display("result %0d expected L=%0d R=%0d st=%0d last=%0d got=%0d fill=%0d",
                         replies_seen, exp.left, exp.right, exp.status, exp.last, exp.got,
                         exp.fill);
                $display("            saw      L=%0d R=%0d st=%0d last=%0d got=%0d fill=%0d",
                         left_out, right_out, status, last, got_count, fill_level);
            end
        end
    endtask

    // Take results, stalling at random, and hold each against the oldest owed reply
    initial
    begin
        ssf_pkg::res_t exp;
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(99, 0) >= recv_stall_pct);
            @(posedge clk);
            if (pop && !empty)
            begin
                replies_seen++;
                status_tally[status]++;
                if (replies_due.size() == 0)
                begin
                    note_mismatch('0, 1'b1);
                end
                else
                begin
                    exp = replies_due.pop_front();
                    if (left_out !== exp.left || right_out !== exp.right ||
                        status !== exp.status || last !== exp.last ||
                        got_count !== exp.got || fill_level !== exp.fill)
                    begin
                        note_mismatch(exp, 1'b0);
                    end
                end
            end
        end
    end

    // Stimulus: directed table, random phases, shutdown table, random after shutdown
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < HEAD_ROWS; i++)
        begin
            play_row(HEAD[i]);
        end
        for (int p = 0; p < PHASES; p++)
        begin
            set_capacity(PHASE_CAP[p]);
            send_idle_pct = PHASE_SEND_IDLE[p];
            recv_stall_pct = PHASE_RECV_STALL[p];
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                random_command(1'b0);
            end
        end
        send_idle_pct = 18;
        recv_stall_pct = 18;
        for (int i = 0; i < TAIL_ROWS; i++)
        begin
            play_row(TAIL[i]);
        end
        set_capacity(11'd5);
        for (int k = 0; k < AFTER_STOP_ITEMS; k++)
        begin
            random_command(1'b1);
        end
        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d commands, checked %0d results over %0d capacity writes",
                 commands_sent, replies_seen, cap_writes);
        $display("Status mix: pushed %0d full %0d dropped %0d popped %0d zero %0d %s %0d %0d %0d",
                 status_tally[ssf_pkg::STAT_PUSHED], status_tally[ssf_pkg::STAT_FULL],
                 status_tally[ssf_pkg::STAT_DROPPED], status_tally[ssf_pkg::STAT_POPPED],
                 status_tally[ssf_pkg::STAT_ZERO], "flushed/shutdown/emptyreq",
                 status_tally[ssf_pkg::STAT_FLUSHED], status_tally[ssf_pkg::STAT_SHUTDOWN],
                 status_tally[ssf_pkg::STAT_EMPTYREQ]);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ssf_pkg.sv
rtl/ssf_front.sv
rtl/ssf_back.sv
rtl/ssf_result_queue.sv
rtl/stereo_sample_fifo_top.sv
bench/testbench.sv
